### hdl/alc_pkg.sv
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, coefficient tables and stage types for the lux calculator.
// ----------------------------------------------------------------------------
package alc_pkg;

   localparam int CntW     = 16;   // raw sensor count
   localparam int ScaleW   = 19;   // channel scale incl. low gain shift
   localparam int ChW      = 22;   // scaled channel value
   localparam int QW       = 11;   // ratio quotient
   localparam int RatioW   = 11;
   localparam int CoefW    = 10;
   localparam int ProdW    = 32;
   localparam int LuxW     = 17;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 8;
   localparam int DivSteps = QW;
   localparam int SelW     = 3;

   localparam logic [LuxW-1:0] LuxSat = 17'h10000;
   localparam logic [LuxW-1:0] LuxMax = 17'h1ffff;
   localparam logic [ProdW:0]  RoundHalf = 33'd8192;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_INTEGRATION_TIME = 2'd0,
      CSR_GAIN_HIGH        = 2'd1,
      CSR_PACKAGE_CS       = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      INT_13MS  = 2'd0,
      INT_101MS = 2'd1,
      INT_402MS = 2'd2
   } int_time_type;

   // breakpoints k1..k7, offsets b1..b8, slopes m1..m8, row 1 is chip scale
   localparam logic [CoefW-1:0] BrkTab [2][7] = '{
      '{10'h040, 10'h080, 10'h0c0, 10'h100, 10'h138, 10'h19a, 10'h29a},
      '{10'h043, 10'h085, 10'h0c8, 10'h10a, 10'h14d, 10'h19a, 10'h29a}
   };
   localparam logic [CoefW-1:0] OffTab [2][8] = '{
      '{10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000},
      '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
   };
   localparam logic [CoefW-1:0] SlopeTab [2][8] = '{
      '{10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000},
      '{10'h1ad, 10'h2c1, 10'h363, 10'h3df, 10'h1dd, 10'h127, 10'h02b, 10'h000}
   };

   function automatic logic [CntW-1:0] clip_limit(input logic [1:0] it);
      logic [CntW-1:0] lim;
      case (it)
         INT_13MS:  lim = 16'd4900;
         INT_101MS: lim = 16'd37000;
         default:   lim = 16'd65000;
      endcase
      return lim;
   endfunction

   function automatic logic [ScaleW-1:0] ch_scale(input logic [1:0] it, input logic gain);
      logic [14:0] base;
      case (it)
         INT_13MS:  base = 15'h7517;
         INT_101MS: base = 15'h0fe7;
         default:   base = 15'h0400;
      endcase
      return gain ? {4'b0, base} : {base, 4'b0};
   endfunction

   // one divider stage: partial remainder, quotient so far and the carried item
   typedef struct packed {
      logic [ChW-1:0] rem;
      logic [QW-1:0]  q;
      logic [ChW-1:0] ch0;
      logic [ChW-1:0] ch1;
      logic           sat;
      logic           over;
      logic           zero;
   } div_type;

endpackage

### hdl/alc_if.sv
// ----------------------------------------------------------------------------
// alc_if
// Valid/ready channels of the lux calculator: sample, result and csr write.
// ----------------------------------------------------------------------------
interface alc_req_if import alc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CntW-1:0] broadband;
   logic [CntW-1:0] infrared;
   modport source(output valid, broadband, infrared, input ready);
   modport sink(input valid, broadband, infrared, output ready);
endinterface

interface alc_rsp_if import alc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [LuxW-1:0] lux;
   logic            saturated;
   modport source(output valid, lux, saturated, input ready);
   modport sink(input valid, lux, saturated, output ready);
endinterface

interface alc_csr_if import alc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] wdata;
   modport source(output valid, index, wdata, input ready);
   modport sink(input valid, index, wdata, output ready);
endinterface

### hdl/ambient_light_lux_calculator.sv
// ----------------------------------------------------------------------------
// ambient_light_lux_calculator
// Two-channel fixed-point illuminance from broadband and infrared counts.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one sample item (broadband, infrared counts); rsp_bus
//   returns one result item (lux, saturated) per sample, in order.
//   csr_bus writes integration_time (index 0), gain_high (1) and
//   package_cs (2); other indexes are ignored. csr_bus.ready is always high.
//   Write configuration only while no sample is in flight.
// Timing:
//   16 register stages: input, channel scaling, eleven ratio division
//   steps (one quotient bit each), coefficient select, products, output.
//   One sample per cycle is accepted and delivered back to back while
//   rsp_bus.ready stays high.
// Stall:
//   each stage moves on when its successor is free, so bubbles squeeze out
//   and the block keeps taking samples until every stage holds an item.
//   req_bus.ready is high whenever rsp_bus.ready is high.
// Reset:
//   synchronous; empties the pipeline and restores integration_time 0,
//   gain_high 1, package_cs 0.
// ----------------------------------------------------------------------------
module ambient_light_lux_calculator import alc_pkg::*; (
   input logic  clock,
   input logic  reset,
   alc_req_if.sink   req_bus,
   alc_rsp_if.source rsp_bus,
   alc_csr_if.sink   csr_bus
);

   // configuration
   logic [1:0] int_time_ff;
   logic       gain_high_ff;
   logic       package_cs_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         int_time_ff   <= INT_13MS;
         gain_high_ff  <= 1'b1;
         package_cs_ff <= 1'b0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_INTEGRATION_TIME: int_time_ff   <= csr_bus.wdata[1:0];
            CSR_GAIN_HIGH:        gain_high_ff  <= csr_bus.wdata[0];
            CSR_PACKAGE_CS:       package_cs_ff <= csr_bus.wdata[0];
            default: ;
         endcase
      end
   end

   // stage valids and advance enables
   logic            in_v_ff, sc_v_ff, sel_v_ff, mul_v_ff, out_v_ff;
   logic            div_v_ff [DivSteps];
   logic            in_en, sc_en, sel_en, mul_en, out_en;
   logic [DivSteps-1:0] div_en;

   assign out_en = !out_v_ff || rsp_bus.ready;
   assign mul_en = !mul_v_ff || out_en;
   assign sel_en = !sel_v_ff || mul_en;

   genvar j;
   generate
      for (j = 0; j < DivSteps; j++) begin : g_en
         if (j == DivSteps - 1) begin : g_last
            assign div_en[j] = !div_v_ff[j] || sel_en;
         end else begin : g_mid
            assign div_en[j] = !div_v_ff[j] || div_en[j+1];
         end
      end
   endgenerate

   assign sc_en = !sc_v_ff || div_en[0];
   assign in_en = !in_v_ff || sc_en;
   assign req_bus.ready = in_en;

   // input stage
   logic [CntW-1:0] bb_ff, ir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else if (in_en) begin
         in_v_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_en) begin
         bb_ff <= req_bus.broadband;
         ir_ff <= req_bus.infrared;
      end
   end

   // scaling stage
   logic [CntW-1:0]        limit;
   logic [ScaleW-1:0]      scale;
   logic [CntW+ScaleW-1:0] prod0, prod1;
   logic [ChW-1:0]         ch0_ff, ch1_ff, ch0_in, ch1_in;
   logic                   sc_sat_ff, sc_sat_in;

   always_comb begin
      limit     = clip_limit(int_time_ff);
      scale     = ch_scale(int_time_ff, gain_high_ff);
      sc_sat_in = (bb_ff > limit) || (ir_ff > limit);
      prod0     = bb_ff * scale;
      prod1     = ir_ff * scale;
      // products stay below 2^32 whenever the item is not saturated
      ch0_in    = prod0[ChW+9:10];
      ch1_in    = prod1[ChW+9:10];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sc_v_ff <= 1'b0;
      end else if (sc_en) begin
         sc_v_ff <= in_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (sc_en) begin
         ch0_ff    <= ch0_in;
         ch1_ff    <= ch1_in;
         sc_sat_ff <= sc_sat_in;
      end
   end

   // ratio division: quotient of (ch1 << 10) / ch0 in QW bits, overflow flagged
   div_type div_init;
   div_type div_ff   [DivSteps];
   div_type div_step [DivSteps];

   always_comb begin
      div_init      = '0;
      div_init.rem  = {1'b0, ch1_ff[ChW-1:1]};
      div_init.ch0  = ch0_ff;
      div_init.ch1  = ch1_ff;
      div_init.sat  = sc_sat_ff;
      // quotient would not fit in QW bits: ratio is past every breakpoint
      div_init.over = {1'b0, ch1_ff} >= {ch0_ff, 1'b0};
      div_init.zero = ch0_ff == '0;
   end

   generate
      for (j = 0; j < DivSteps; j++) begin : g_div
         if (j == 0) begin : g_first
            alc_div_step u_step (
               .d_in    (div_init),
               .num_bit (ch1_ff[0]),
               .d_out   (div_step[j])
            );
            always_ff @(posedge clock) begin
               if (reset) begin
                  div_v_ff[j] <= 1'b0;
               end else if (div_en[j]) begin
                  div_v_ff[j] <= sc_v_ff;
               end
            end
         end else begin : g_rest
            alc_div_step u_step (
               .d_in    (div_ff[j-1]),
               .num_bit (1'b0),
               .d_out   (div_step[j])
            );
            always_ff @(posedge clock) begin
               if (reset) begin
                  div_v_ff[j] <= 1'b0;
               end else if (div_en[j]) begin
                  div_v_ff[j] <= div_v_ff[j-1];
               end
            end
         end
         always_ff @(posedge clock) begin
            if (div_en[j]) begin
               div_ff[j] <= div_step[j];
            end
         end
      end
   endgenerate

   // coefficient select
   div_type          div_last;
   logic [QW:0]      q_round;
   logic [RatioW-1:0] ratio;
   logic [SelW-1:0]  sel;
   logic [CoefW-1:0] off_ff, slope_ff, off_in, slope_in;
   logic [ChW-1:0]   sel_ch0_ff, sel_ch1_ff;
   logic             sel_sat_ff;

   assign div_last = div_ff[DivSteps-1];

   always_comb begin
      q_round = {1'b0, div_last.q} + (QW+1)'(1);
      ratio   = div_last.zero ? '0 : q_round[QW:1];
      sel     = SelW'(7);
      for (int i = 6; i >= 0; i--) begin
         if ({1'b0, ratio} <= {2'b0, BrkTab[package_cs_ff][i]}) begin
            sel = SelW'(i);
         end
      end
      if (div_last.over && !div_last.zero) begin
         sel = SelW'(7);
      end
      off_in   = OffTab[package_cs_ff][sel];
      slope_in = SlopeTab[package_cs_ff][sel];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_v_ff <= 1'b0;
      end else if (sel_en) begin
         sel_v_ff <= div_v_ff[DivSteps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (sel_en) begin
         off_ff     <= off_in;
         slope_ff   <= slope_in;
         sel_ch0_ff <= div_last.ch0;
         sel_ch1_ff <= div_last.ch1;
         sel_sat_ff <= div_last.sat;
      end
   end

   // products
   logic [ProdW-1:0] pos_ff, neg_ff;
   logic             mul_sat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_v_ff <= 1'b0;
      end else if (mul_en) begin
         mul_v_ff <= sel_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         pos_ff     <= sel_ch0_ff * off_ff;
         neg_ff     <= sel_ch1_ff * slope_ff;
         mul_sat_ff <= sel_sat_ff;
      end
   end

   // difference, rounding and output register
   logic [ProdW-1:0] diff;
   logic [ProdW:0]   rounded;
   logic [ProdW-14:0] shifted;
   logic [LuxW-1:0]  lux_ff, lux_in;
   logic             sat_ff;

   always_comb begin
      diff    = (pos_ff > neg_ff) ? pos_ff - neg_ff : '0;
      rounded = {1'b0, diff} + RoundHalf;
      shifted = rounded[ProdW:14];
      if (mul_sat_ff) begin
         lux_in = LuxSat;
      end else if (shifted > {2'b0, LuxMax}) begin
         lux_in = LuxMax;
      end else begin
         lux_in = shifted[LuxW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_en) begin
         out_v_ff <= mul_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         lux_ff <= lux_in;
         sat_ff <= mul_sat_ff;
      end
   end

   assign rsp_bus.valid     = out_v_ff;
   assign rsp_bus.lux       = lux_ff;
   assign rsp_bus.saturated = sat_ff;

endmodule

### hdl/alc_div_step.sv
// ----------------------------------------------------------------------------
// alc_div_step
// One restoring division step: shift in a numerator bit, compare, subtract.
// ----------------------------------------------------------------------------
module alc_div_step import alc_pkg::*; (
   input  div_type d_in,
   input  logic    num_bit,
   output div_type d_out
);

   logic [ChW:0] trial;
   logic         ge;

   always_comb begin
      trial = {d_in.rem, num_bit};
      ge    = trial >= {1'b0, d_in.ch0};
      d_out = d_in;
      d_out.rem = ge ? ChW'(trial - {1'b0, d_in.ch0}) : trial[ChW-1:0];
      d_out.q   = {d_in.q[QW-2:0], ge};
   end

endmodule

### hdl/alc_checker.sv
// ----------------------------------------------------------------------------
// alc_checker
// Port-level checks of the lux calculator, bound onto the top level.
// ----------------------------------------------------------------------------
module alc_checker import alc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic [LuxW-1:0] rsp_lux,
   input logic            rsp_saturated
);

   // reset empties the output stage
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a saturated item always reports the fixed saturation value
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_lux == LuxSat)
      else $error("saturated item with wrong lux");

   // a draining output never holds back the sample side
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("sample side stalled while result side drains");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lux) && $stable(rsp_saturated))
      else $error("stalled result changed");

endmodule

bind ambient_light_lux_calculator alc_checker u_alc_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_lux       (rsp_bus.lux),
   .rsp_saturated (rsp_bus.saturated)
);
